>>> design/lr_pkg.sv
// Shared types and constants for the line rasterizer.
package lr_pkg;

    localparam int COORD_W = 6;
    localparam int INDEX_W = 12;
    localparam int COLOR_W = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // One classified line, ready for the walker.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               x_inc;
        logic               y_inc;
        logic               shallow;
        logic [COORD_W-1:0] d_major;
        logic [COORD_W-1:0] d_minor;
        logic [COLOR_W-1:0] color;
    } t_job;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_walk_state;

endpackage

>>> design/lr_front.sv
// Front end: clamps the end points, derives deltas and step directions, queues the job.
module lr_front #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lr_pkg::COORD_W-1:0]   i_x_start,
    input  logic [lr_pkg::COORD_W-1:0]   i_y_start,
    input  logic [lr_pkg::COORD_W-1:0]   i_x_end,
    input  logic [lr_pkg::COORD_W-1:0]   i_y_end,
    input  logic [lr_pkg::COLOR_W-1:0]   i_line_color,
    input  lr_pkg::t_q_stat              i_q_stat,
    output logic                         o_push,
    output lr_pkg::t_job                 o_job
);

    localparam logic [lr_pkg::COORD_W-1:0] X_MAX = lr_pkg::COORD_W'(SCREEN_WIDTH - 1);
    localparam logic [lr_pkg::COORD_W-1:0] Y_MAX = lr_pkg::COORD_W'(SCREEN_HEIGHT - 1);

    logic [lr_pkg::COORD_W-1:0] xs, ys, xe, ye, dx, dy;
    logic                       x_inc, y_inc, shallow;

    always_comb begin
        xs = (i_x_start > X_MAX) ? X_MAX : i_x_start;
        ys = (i_y_start > Y_MAX) ? Y_MAX : i_y_start;
        xe = (i_x_end   > X_MAX) ? X_MAX : i_x_end;
        ye = (i_y_end   > Y_MAX) ? Y_MAX : i_y_end;
        x_inc   = (xe >= xs);
        y_inc   = (ye >= ys);
        dx      = x_inc ? (xe - xs) : (xs - xe);
        dy      = y_inc ? (ye - ys) : (ys - ye);
        shallow = (dx > dy);

        o_job.x       = xs;
        o_job.y       = ys;
        o_job.x_inc   = x_inc;
        o_job.y_inc   = y_inc;
        o_job.shallow = shallow;
        o_job.d_major = shallow ? dx : dy;
        o_job.d_minor = shallow ? dy : dx;
        o_job.color   = i_line_color;
    end

    assign o_in_ready = !i_q_stat.full;
    // zero-length lines are taken and dropped here
    assign o_push = i_in_valid && o_in_ready && (o_job.d_major != '0);

endmodule

>>> design/lr_queue.sv
// Two-entry job queue between the front end and the walker.
module lr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lr_pkg::t_job    i_job,
    input  logic            i_pop,
    output lr_pkg::t_job    o_job,
    output lr_pkg::t_q_stat o_stat
);

    lr_pkg::t_job               r_mem [lr_pkg::Q_DEPTH];
    logic [lr_pkg::Q_PTR_W-1:0] r_wptr, n_wptr, r_rptr, n_rptr;
    logic [lr_pkg::Q_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rptr];
    assign o_stat.full  = (r_count == lr_pkg::Q_CNT_W'(lr_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

>>> design/lr_walk.sv
// Back end: Bresenham error walk, one pixel per cycle into an output register while not stalled.
module lr_walk #(
    parameter int SCREEN_WIDTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lr_pkg::t_q_stat              i_q_stat,
    input  lr_pkg::t_job                 i_job,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lr_pkg::INDEX_W-1:0]   o_pixel_index,
    output logic [lr_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                         o_last_pixel
);

    localparam logic [lr_pkg::INDEX_W-1:0] ROW_PITCH = lr_pkg::INDEX_W'(SCREEN_WIDTH);

    lr_pkg::t_walk_state          r_state, n_state;
    lr_pkg::t_job                 r_job;
    logic [lr_pkg::COORD_W-1:0]   r_x, r_y, r_cnt;
    logic signed [lr_pkg::COORD_W:0] r_e, e_t, n_e;
    logic [lr_pkg::COORD_W-1:0]   n_x, n_y;
    logic                         minor_step, adv;
    logic                         r_out_valid;
    logic [lr_pkg::INDEX_W-1:0]   r_index, pix_index;
    logic [lr_pkg::COLOR_W-1:0]   r_color;
    logic                         r_last;

    assign o_pop = (r_state == lr_pkg::ST_IDLE) && !i_q_stat.empty;
    assign adv   = (r_state == lr_pkg::ST_RUN) && (!r_out_valid || i_out_ready);

    always_comb begin
        e_t        = r_e - $signed({1'b0, r_job.d_minor});
        minor_step = e_t[lr_pkg::COORD_W];
        n_e        = minor_step ? (e_t + $signed({1'b0, r_job.d_major})) : e_t;
        n_x = r_x;
        n_y = r_y;
        if (r_job.shallow || minor_step) begin
            n_x = r_job.x_inc ? (r_x + 1'b1) : (r_x - 1'b1);
        end
        if (!r_job.shallow || minor_step) begin
            n_y = r_job.y_inc ? (r_y + 1'b1) : (r_y - 1'b1);
        end
        pix_index = lr_pkg::INDEX_W'(r_x) + ROW_PITCH * lr_pkg::INDEX_W'(r_y);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lr_pkg::ST_IDLE: begin
                if (o_pop) begin
                    n_state = lr_pkg::ST_RUN;
                end
            end
            lr_pkg::ST_RUN: begin
                if (adv && r_cnt == lr_pkg::COORD_W'(1)) begin
                    n_state = lr_pkg::ST_IDLE;
                end
            end
            default: n_state = lr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_x   <= i_job.x;
            r_y   <= i_job.y;
            r_cnt <= i_job.d_major;
            r_e   <= $signed({2'b00, i_job.d_major[lr_pkg::COORD_W-1:1]});
        end else if (adv) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_e   <= n_e;
            r_cnt <= r_cnt - 1'b1;
        end
        if (adv) begin
            r_index <= pix_index;
            r_color <= r_job.color;
            r_last  <= (r_cnt == lr_pkg::COORD_W'(1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_index;
    assign o_pixel_color = r_color;
    assign o_last_pixel  = r_last;

endmodule

>>> design/line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
// Input channel (i_in_valid / o_in_ready) takes one segment per transfer: start
// and end coordinates and a 32-bit color. Output channel (o_out_valid /
// i_out_ready) gives one framebuffer write per transfer: word index
// x + SCREEN_WIDTH*y, the color, and o_last_pixel on the final write of a line.
// A line gives max(|dx|,|dy|) writes; the end point is not drawn and a
// zero-length line is taken and gives nothing. Coordinates past the screen
// edge are saturated to the last column or row.
// The front end classifies a segment in the cycle it is taken and puts it in a
// two-entry queue; it keeps taking segments while the queue has room.
// The walker loads a job from the queue into its job register, then makes one
// pixel per cycle while the receiver accepts; it takes the next job only after
// the last pixel of the line before it.
// When the receiver stalls the output register holds and the walk pauses;
// the queue then fills and o_in_ready drops.
// Synchronous active-low reset empties the queue, idles the walker and
// clears o_out_valid.
module line_rasterizer #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lr_pkg::COORD_W-1:0]   i_x_start,
    input  logic [lr_pkg::COORD_W-1:0]   i_y_start,
    input  logic [lr_pkg::COORD_W-1:0]   i_x_end,
    input  logic [lr_pkg::COORD_W-1:0]   i_y_end,
    input  logic [lr_pkg::COLOR_W-1:0]   i_line_color,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lr_pkg::INDEX_W-1:0]   o_pixel_index,
    output logic [lr_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                         o_last_pixel
);

    lr_pkg::t_q_stat q_stat;
    lr_pkg::t_job    push_job, pop_job;
    logic            push, pop;

    lr_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_line_color (i_line_color),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_job        (push_job)
    );

    lr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    lr_walk #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_job         (pop_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= lr_pkg::Q_CNT_W'(lr_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_index)
            && $stable(o_pixel_color) && $stable(o_last_pixel))
        else $error("write changed while stalled");
`endif

endmodule
